[hw/rtl/smld_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smld_pkg
// Shared types and constants of the sliding-window median delay block.
// ----------------------------------------------------------------------------
package smld_pkg;

    localparam int unsigned WINDOW    = 256;
    localparam int unsigned ROWS      = 16;
    localparam int unsigned ROW_W     = $clog2(ROWS);
    localparam int unsigned SLOT_W    = $clog2(WINDOW);
    localparam int unsigned FILL_W    = $clog2(WINDOW + 1);
    localparam int unsigned ADDR_W    = ROW_W + SLOT_W;
    localparam int unsigned QUOTA_W   = 9;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned DELAY_W   = 33;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned PADDR_W   = 3;

    // Register byte addresses.
    localparam logic [PADDR_W-1:0] REG_ENABLE = 3'h0;
    localparam logic [PADDR_W-1:0] REG_QUOTA  = 3'h4;

    // Item codes.
    localparam logic FUNC_SAMPLE  = 1'b0;
    localparam logic FUNC_SESSION = 1'b1;

    typedef struct packed {
        logic              func;
        logic              kind;
        logic [3:0]        row;
        logic [VAL_W-1:0]  interval_us;
        logic [FRAC_W-1:0] rand_frac;
    } t_in_beat;

    typedef struct packed {
        logic [DELAY_W-1:0] delay_us;
        logic [VAL_W-1:0]   median_us;
        logic               quota_exceeded;
        logic               recorded;
    } t_out_beat;

endpackage
`default_nettype wire

[hw/rtl/smld_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smld_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module smld_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_addr,
    input  wire [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Registered read; a write cycle returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

[hw/rtl/sliding_median_login_delay.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_median_login_delay
// Per-row sliding window of intervals; answers a delay from the window median.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        input      i_in_valid/o_in_ready  i_in  (t_in_beat)
// out       output     o_out_valid/i_out_ready o_out (t_out_beat)
// cfg       input      APB psel/penable/pready pwdata/prdata
//
// A sample beat is worked on by a bitwise radix select that makes one pass over
// the row's window memory (n entries, n the row's fill count, at most 256) per
// result bit, one read per cycle. Session and ignored beats need no pass.
// Reset clears fill counts, write slots and session counters; the window memory
// needs no clearing. One beat is in work at a time; the result waits in the
// output register and the next beat is taken once the result has been taken.
module sliding_median_login_delay (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire smld_pkg::t_in_beat           i_in,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output smld_pkg::t_out_beat               o_out,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [smld_pkg::PADDR_W-1:0]       paddr,
    input  wire [31:0]                        pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_BIT, S_MULT, S_DONE
    } t_state;

    t_state r_state;
    logic                            r_enable;
    logic [smld_pkg::QUOTA_W-1:0]    r_quota;
    logic [smld_pkg::FILL_W-1:0]     r_fill [smld_pkg::ROWS];
    logic [smld_pkg::SLOT_W-1:0]     r_slot [smld_pkg::ROWS];
    logic [smld_pkg::QUOTA_W-1:0]    r_adds [2];
    smld_pkg::t_in_beat              r_item;
    logic [smld_pkg::FILL_W-1:0]     r_n;
    logic [smld_pkg::FILL_W:0]       r_idx;
    logic [smld_pkg::FILL_W:0]       r_k;
    logic [smld_pkg::FILL_W:0]       r_cnt;
    logic [smld_pkg::VAL_W-1:0]      r_prefix;
    logic [smld_pkg::VAL_W-1:0]      r_mask;
    logic [4:0]                      r_bit;
    logic                            r_rd_ok;
    logic [smld_pkg::VAL_W-1:0]      r_d;
    logic [47:0]                     r_prod;
    logic                            r_wr;
    logic                            r_out_valid;
    smld_pkg::t_out_beat             r_out;

    logic                            cfg_wr;
    logic [smld_pkg::ADDR_W-1:0]     ram_addr;
    logic [smld_pkg::VAL_W-1:0]      ram_rdata;
    logic                            ram_we;
    logic [smld_pkg::VAL_W-1:0]      cur_bit;
    logic [smld_pkg::VAL_W-1:0]      rd_val;
    logic                            rd_match;
    logic                            cur_match;
    logic [smld_pkg::FILL_W:0]       cnt_next;
    logic                            can_add;
    logic [smld_pkg::VAL_W-1:0]      n_med;
    logic [smld_pkg::VAL_W-1:0]      med_diff;

    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;
    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Register read-back.
    always_comb begin
        case (paddr)
            smld_pkg::REG_ENABLE: prdata = {31'd0, r_enable};
            smld_pkg::REG_QUOTA:  prdata = {23'd0, r_quota};
            default:              prdata = 32'd0;
        endcase
    end

    // Radix select: count candidates whose bit is zero under the prefix.
    assign cur_bit   = 32'd1 << r_bit;
    assign rd_val    = ram_rdata;
    assign rd_match  = r_rd_ok && (((rd_val & r_mask) == r_prefix) && !(|(rd_val & cur_bit)));
    assign cur_match = ((r_item.interval_us & r_mask) == r_prefix)
                       && !(|(r_item.interval_us & cur_bit));
    assign cnt_next  = r_cnt + {{smld_pkg::FILL_W{1'b0}}, rd_match};
    assign can_add   = r_adds[r_item.kind] < r_quota;
    assign n_med     = r_prefix;
    assign med_diff  = n_med - r_item.interval_us;

    // Window memory: scan address or the write slot, whose pointer has
    // already advanced when the write takes place.
    assign ram_we   = r_wr;
    assign ram_addr = r_wr ? {r_item.row, r_slot[r_item.row] - 1'b1}
                           : {r_item.row, r_idx[smld_pkg::SLOT_W-1:0]};

    smld_ram #(
        .WIDTH(smld_pkg::VAL_W),
        .DEPTH(smld_pkg::ROWS * smld_pkg::WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_item.interval_us),
        .o_rdata (ram_rdata)
    );

    // Sequencer, state tables and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b1;
            r_quota     <= 9'd16;
            r_adds[0]   <= '0;
            r_adds[1]   <= '0;
            r_out_valid <= 1'b0;
            r_wr        <= 1'b0;
            r_rd_ok     <= 1'b0;
            for (int i = 0; i < smld_pkg::ROWS; i++) begin
                r_fill[i] <= '0;
                r_slot[i] <= '0;
            end
        end else begin
            r_wr <= 1'b0;
            if (cfg_wr && paddr == smld_pkg::REG_ENABLE) begin
                r_enable <= pwdata[0];
            end
            if (cfg_wr && paddr == smld_pkg::REG_QUOTA) begin
                r_quota <= pwdata[smld_pkg::QUOTA_W-1:0];
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_item <= i_in;
                        r_out  <= '0;
                        if (!r_enable) begin
                            r_out_valid <= 1'b1;
                        end else if (i_in.func == smld_pkg::FUNC_SESSION) begin
                            r_adds[0]   <= '0;
                            r_adds[1]   <= '0;
                            r_out_valid <= 1'b1;
                        end else begin
                            r_n      <= r_fill[i_in.row];
                            r_k      <= {1'b0, (r_fill[i_in.row] + 1'b1) >> 1};
                            r_prefix <= '0;
                            r_mask   <= '0;
                            r_bit    <= 5'd31;
                            r_idx    <= '0;
                            r_cnt    <= '0;
                            r_rd_ok  <= 1'b0;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // One read per cycle; data of index idx-1 arrives now.
                    r_cnt   <= cnt_next;
                    r_rd_ok <= (r_idx < {1'b0, r_n});
                    r_idx   <= r_idx + 1'b1;
                    if (r_idx == {1'b0, r_n} + 1'b1) begin
                        r_state <= S_BIT;
                    end
                end
                S_BIT: begin
                    // Zeros at this bit cover index k: keep 0, else take 1.
                    if ((r_cnt + {{smld_pkg::FILL_W{1'b0}}, cur_match}) <= r_k) begin
                        r_k      <= r_k - r_cnt - {{smld_pkg::FILL_W{1'b0}}, cur_match};
                        r_prefix <= r_prefix | cur_bit;
                    end
                    r_mask  <= r_mask | cur_bit;
                    r_idx   <= '0;
                    r_cnt   <= '0;
                    r_rd_ok <= 1'b0;
                    if (r_bit == 5'd0) begin
                        r_state <= S_MULT;
                    end else begin
                        r_bit   <= r_bit - 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_MULT: begin
                    // Shortfall and the full product of its half with the fraction.
                    r_d     <= (r_item.interval_us < n_med) ? med_diff : '0;
                    r_prod  <= {17'd0, med_diff[smld_pkg::VAL_W-1:1]}
                             * {32'd0, r_item.rand_frac};
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_out.median_us <= n_med;
                    r_out.delay_us  <= (r_d == '0) ? '0
                                     : {1'b0, r_d} + 33'(r_prod >> 16);
                    if (can_add) begin
                        r_wr <= 1'b1;
                        r_slot[r_item.row] <= r_slot[r_item.row] + 1'b1;
                        if (r_fill[r_item.row] < smld_pkg::FILL_W'(smld_pkg::WINDOW)) begin
                            r_fill[r_item.row] <= r_fill[r_item.row] + 1'b1;
                        end
                        r_adds[r_item.kind] <= r_adds[r_item.kind] + 1'b1;
                        r_out.recorded <= 1'b1;
                    end else begin
                        r_out.quota_exceeded <= 1'b1;
                    end
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.recorded && o_out.quota_exceeded))
        else $error("recorded and quota flag both set");
    a_wr_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr |-> $past(r_state) == S_DONE) else $error("stray window write");
    a_delay_med: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.delay_us != '0) |-> o_out.median_us > o_out.delay_us[31:0] ||
        o_out.delay_us[32] || o_out.median_us != '0) else $error("delay without median");
`endif
endmodule
`default_nettype wire
